// File: hw/rtl/blsp_pkg.sv
// shared types, opcodes and seven-segment table for the pad link
package blsp_pkg;

    // host request codes carried in the input tuser
    localparam logic [2:0] CMD_DEVICE_PKT = 3'd0;
    localparam logic [2:0] CMD_INIT       = 3'd1;
    localparam logic [2:0] CMD_SET_LED    = 3'd2;
    localparam logic [2:0] CMD_READ_BTN   = 3'd3;

    // device packet opcodes
    localparam logic [7:0] OP_ACK           = 8'd64;
    localparam logic [7:0] OP_BUTTON_EVENT  = 8'd65;
    localparam logic [7:0] OP_DEVICE_RESET  = 8'd66;
    // opcodes sent to the device
    localparam logic [7:0] OP_LED_SET       = 8'd6;
    localparam logic [7:0] OP_BUTTON_IRQ_ON = 8'd3;
    localparam logic [7:0] OP_LED_USER_MODE = 8'd11;

    // second byte of the led packet: all four digits addressed
    localparam logic [7:0] LED_DIGIT_MASK = 8'h0F;
    // segment bit that lights the decimal point
    localparam logic [7:0] SEG_DP         = 8'h10;

    localparam int MAX_BYTES = 8;
    localparam int IDX_W     = $clog2(MAX_BYTES);

    // one input item after unpacking
    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  packet_opcode;
        logic [7:0]  packet_first_arg;
        logic [7:0]  packet_second_arg;
        logic [31:0] led_word;
    } t_item;

    // the results one item causes, held while they drain
    typedef struct packed {
        logic                            any;        // at least one result
        logic                            send_valid;
        logic                            status;
        logic [IDX_W-1:0]                last_idx;
        logic [MAX_BYTES-1:0][7:0]       bytes;
        logic [7:0]                      buttons;
    } t_burst;

    // link state kept between items
    typedef struct packed {
        logic [7:0]  button_map;
        logic [31:0] saved_led_word;
        logic        ack_ready;
    } t_link_state;

    // seven-segment code of one hex digit
    function automatic logic [7:0] seg_code(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'h0: c = 8'hE7;
            4'h1: c = 8'h06;
            4'h2: c = 8'hCB;
            4'h3: c = 8'h8F;
            4'h4: c = 8'h2E;
            4'h5: c = 8'hAD;
            4'h6: c = 8'hED;
            4'h7: c = 8'h86;
            4'h8: c = 8'hEF;
            4'h9: c = 8'hAF;
            4'hA: c = 8'hEE;
            4'hB: c = 8'h6D;
            4'hC: c = 8'hE1;
            4'hD: c = 8'h4F;
            4'hE: c = 8'hE9;
            default: c = 8'hE8;
        endcase
        return c;
    endfunction

    // digit byte: blank when disabled, decimal point added when asked
    function automatic logic [7:0] digit_byte(input logic [3:0] nib, input logic en,
                                              input logic dp);
        logic [7:0] c;
        c = seg_code(nib);
        if (!en) begin
            c = 8'h00;
        end else if (dp) begin
            c = c | SEG_DP;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/blsp_pkt_build.sv
// decodes one item into its byte burst and the next link state
module blsp_pkt_build import blsp_pkg::*; (
    input  t_item       i_item,
    input  t_link_state i_state,
    output t_burst      o_burst,
    output t_link_state o_state
);

    logic [5:0][7:0] led_pkt;
    logic [7:0]      btn_next;
    logic [7:0]      nb;
    logic [7:0]      nc;
    logic [31:0]     led_src;
    logic [7:0]      b_map;

    // word whose led packet is sent: stored word on device reset, new word otherwise
    assign led_src = (i_item.command == CMD_SET_LED) ? i_item.led_word
                                                     : i_state.saved_led_word;

    // led packet for the chosen word
    always_comb begin
        led_pkt[0] = OP_LED_SET;
        led_pkt[1] = LED_DIGIT_MASK;
        for (int i = 0; i < 4; i++) begin
            led_pkt[2+i] = digit_byte(led_src[4*i +: 4], led_src[16+i], led_src[24+i]);
        end
    end

    // active-low pad bytes into the active-high button map
    assign nb = ~i_item.packet_first_arg;
    assign nc = ~i_item.packet_second_arg;
    assign btn_next = {nc[3], nc[1], nc[2], nc[0], nb[3:0]};

    // per-command burst and state update
    always_comb begin
        o_state            = i_state;
        o_burst.any        = 1'b1;
        o_burst.send_valid = 1'b0;
        o_burst.status     = 1'b0;
        o_burst.last_idx   = '0;
        o_burst.bytes      = '0;
        case (i_item.command)
            CMD_DEVICE_PKT: begin
                o_burst.any = 1'b0;
                if (i_item.packet_opcode == OP_ACK) begin
                    o_state.ack_ready = 1'b1;
                end else if (i_item.packet_opcode == OP_BUTTON_EVENT) begin
                    o_state.button_map = btn_next;
                end else if (i_item.packet_opcode == OP_DEVICE_RESET) begin
                    o_burst.any        = 1'b1;
                    o_burst.send_valid = 1'b1;
                    o_burst.last_idx   = IDX_W'(MAX_BYTES - 1);
                    o_burst.bytes[0]   = OP_BUTTON_IRQ_ON;
                    o_burst.bytes[1]   = OP_LED_USER_MODE;
                    for (int i = 0; i < 6; i++) begin
                        o_burst.bytes[2+i] = led_pkt[i];
                    end
                    o_state.button_map = '0;
                    o_state.ack_ready  = 1'b0;
                end
            end
            CMD_INIT: begin
                o_burst.send_valid = 1'b1;
                o_burst.last_idx   = IDX_W'(1);
                o_burst.bytes[0]   = OP_BUTTON_IRQ_ON;
                o_burst.bytes[1]   = OP_LED_USER_MODE;
                o_state            = '0;
            end
            CMD_SET_LED: begin
                if (i_state.ack_ready) begin
                    o_burst.send_valid     = 1'b1;
                    o_burst.last_idx       = IDX_W'(5);
                    for (int i = 0; i < 6; i++) begin
                        o_burst.bytes[i] = led_pkt[i];
                    end
                    o_state.ack_ready      = 1'b0;
                    o_state.saved_led_word = i_item.led_word;
                end
            end
            CMD_READ_BTN: begin
                o_burst.status = 1'b0;
            end
            default: begin
                o_burst.status = 1'b1;
            end
        endcase
        // results carry the map as it stands after this item
        b_map           = o_state.button_map;
        o_burst.buttons = b_map;
    end

endmodule

// File: hw/rtl/button_led_serial_pad_link.sv
// top level of the keypad-and-display serial link, host side
// An item is registered on entry, decoded in one pass into its burst of
// results, and the burst drains one result per cycle through an output
// register when the output is not stalled. A host request gives one
// result; init gives two, set-LEDs six when an acknowledge is pending and a
// device reset eight. The next item is taken while a burst drains and
// moves into decode as the last byte leaves, so bursts follow each other
// without gaps. Acknowledge, button-event and unknown device packets give
// no result.
module button_led_serial_pad_link import blsp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: packet_opcode[7:0], packet_first_arg[15:8], packet_second_arg[23:16],
    //        led_word[55:24]
    input  logic [55:0] s_axis_tdata,
    // tuser: command[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: send_byte[7:0], buttons[15:8]
    output logic [15:0] m_axis_tdata,
    // tuser: send_valid[0], status[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic             r_in_valid;
    t_item            r_in;
    t_link_state      r_state;
    t_link_state      n_state;
    t_burst           n_burst;
    logic             r_b_valid;
    t_burst           r_b;
    logic [IDX_W-1:0] r_b_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [7:0]       r_out_buttons;
    logic             r_out_send;
    logic             r_out_status;
    logic             r_out_last;

    logic out_adv;
    logic b_fire;
    logic b_done;
    logic move_in;

    // handshake between the stages
    assign out_adv       = !r_out_valid || m_axis_tready;
    assign b_fire        = r_b_valid && out_adv;
    assign b_done        = b_fire && (r_b_idx == r_b.last_idx);
    assign move_in       = r_in_valid && (!r_b_valid || b_done);
    assign s_axis_tready = !r_in_valid || move_in;

    // decode of the registered item
    blsp_pkt_build u_build (
        .i_item  (r_in),
        .i_state (r_state),
        .o_burst (n_burst),
        .o_state (n_state)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.command           <= s_axis_tuser;
            r_in.packet_opcode     <= s_axis_tdata[7:0];
            r_in.packet_first_arg  <= s_axis_tdata[15:8];
            r_in.packet_second_arg <= s_axis_tdata[23:16];
            r_in.led_word          <= s_axis_tdata[55:24];
        end
    end

    // link state, updated as an item enters decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (move_in) begin
            r_state <= n_state;
        end
    end

    // burst register and its byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= '0;
        end else if (move_in) begin
            r_b_valid <= n_burst.any;
            r_b_idx   <= '0;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= '0;
        end else if (b_fire) begin
            r_b_idx   <= r_b_idx + 1'b1;
        end
        if (move_in) begin
            r_b <= n_burst;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_b_valid;
        end
        if (b_fire) begin
            r_out_byte    <= r_b.bytes[r_b_idx];
            r_out_buttons <= r_b.buttons;
            r_out_send    <= r_b.send_valid;
            r_out_status  <= r_b.status;
            r_out_last    <= (r_b_idx == r_b.last_idx);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_buttons, r_out_byte};
    assign m_axis_tuser  = {r_out_status, r_out_send};
    assign m_axis_tlast  = r_out_last;

endmodule
